@@ rtl/bmpu_pkg.sv @@
// Package for the BMP pixel unpacker: register codes, dimension limits and the
// record types passed between the unpacker modules. No dependencies.
`default_nettype none

package bmpu_pkg;

   localparam int unsigned DimWidth     = 13;
   localparam int unsigned CountWidth   = 12;
   localparam int unsigned IndexWidth   = 24;
   localparam int unsigned CsrIndexBits = 3;

   localparam logic [DimWidth-1:0] MaxWidth  = 13'd4096;
   localparam logic [DimWidth-1:0] MaxHeight = 13'd4096;
   localparam logic [7:0]          OpaqueAlpha = 8'd255;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_HAS_ALPHA    = 3'd2,
      CSR_BOTTOM_UP    = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [DimWidth-1:0] width;
      logic [DimWidth-1:0] height;
      logic                has_alpha;
      logic                bottom_up;
   } image_cfg_type;

   typedef struct packed {
      logic [CountWidth-1:0] dest_row;
      logic [CountWidth-1:0] column;
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
      logic [7:0]            alpha;
      logic                  last;
   } pixel_rec_type;

   // A dimension of zero acts as one; anything above the limit acts as the limit.
   function automatic logic [DimWidth-1:0] clamp_dim(input logic [DimWidth-1:0] value,
                                                     input logic [DimWidth-1:0] limit);
      logic [DimWidth-1:0] result;
      if (value == '0) begin
         result = DimWidth'(1);
      end else if (value > limit) begin
         result = limit;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

@@ rtl/bmpu_stream_if.sv @@
// Valid/ready channel interfaces for the BMP pixel unpacker: the byte input
// channel and the RGBA pixel result channel. No dependencies.
`default_nettype none

interface bmpu_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface bmpu_pixel_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_index;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;
   logic        last;

   modport source (output valid, output pixel_index, output red, output green,
                   output blue, output alpha, output last, input ready);
   modport sink   (input valid, input pixel_index, input red, input green,
                   input blue, input alpha, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/bmpu_assembler.sv @@
// Byte assembler for the BMP pixel unpacker: gathers pixel bytes, skips row
// padding and tracks stored row and column. Depends on bmpu_pkg.
`default_nettype none

module bmpu_assembler (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    restart,
   input  wire bmpu_pkg::image_cfg_type cfg,
   input  wire logic                    byte_take,
   input  wire logic [7:0]              data_byte,
   output      logic                    pixel_done,
   output      bmpu_pkg::pixel_rec_type pixel
);

   logic [1:0]                        phase_ff, phase_in;
   logic [23:0]                       held_ff, held_in;
   logic [bmpu_pkg::CountWidth-1:0]   column_ff, column_in;
   logic [bmpu_pkg::CountWidth-1:0]   row_ff, row_in;
   logic [1:0]                        pad_ff, pad_in;
   logic                              done_ff, done_in;

   logic [1:0]                        last_phase;
   logic [bmpu_pkg::CountWidth-1:0]   width_last;
   logic [bmpu_pkg::CountWidth-1:0]   height_last;
   logic                              row_end;

   always_comb begin
      last_phase  = cfg.has_alpha ? 2'd3 : 2'd2;
      width_last  = bmpu_pkg::CountWidth'(cfg.width - bmpu_pkg::DimWidth'(1));
      height_last = bmpu_pkg::CountWidth'(cfg.height - bmpu_pkg::DimWidth'(1));
      row_end     = (column_ff == width_last);

      phase_in   = phase_ff;
      held_in    = held_ff;
      column_in  = column_ff;
      row_in     = row_ff;
      pad_in     = pad_ff;
      done_in    = done_ff;
      pixel_done = 1'b0;

      if (byte_take && !done_ff) begin
         if (pad_ff != 2'd0) begin
            pad_in = pad_ff - 2'd1;
         end else if (phase_ff != last_phase) begin
            case (phase_ff)
               2'd0:    held_in[7:0]   = data_byte;
               2'd1:    held_in[15:8]  = data_byte;
               default: held_in[23:16] = data_byte;
            endcase
            phase_in = phase_ff + 2'd1;
         end else begin
            pixel_done = 1'b1;
            phase_in   = 2'd0;
            if (row_end) begin
               column_in = '0;
               row_in    = row_ff + bmpu_pkg::CountWidth'(1);
               pad_in    = cfg.has_alpha ? 2'd0 : cfg.width[1:0];
               done_in   = (row_ff == height_last);
            end else begin
               column_in = column_ff + bmpu_pkg::CountWidth'(1);
            end
         end
      end

      if (restart) begin
         phase_in  = 2'd0;
         column_in = '0;
         row_in    = '0;
         pad_in    = 2'd0;
         done_in   = 1'b0;
      end
   end

   always_comb begin
      pixel.dest_row = cfg.bottom_up ? (height_last - row_ff) : row_ff;
      pixel.column   = column_ff;
      pixel.green    = held_ff[15:8];
      pixel.blue     = held_ff[7:0];
      pixel.last     = (row_ff == height_last) && row_end;
      if (cfg.has_alpha) begin
         pixel.red   = held_ff[23:16];
         pixel.alpha = data_byte;
      end else begin
         pixel.red   = data_byte;
         pixel.alpha = bmpu_pkg::OpaqueAlpha;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 2'd0;
         column_ff <= '0;
         row_ff    <= '0;
         pad_ff    <= 2'd0;
         done_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         pad_ff    <= pad_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

`default_nettype wire

@@ rtl/bmp_pixel_unpack_rgba.sv @@
// Top level of the BMP pixel unpacker: configuration registers, pixel record
// stage and result register. Depends on bmpu_pkg, bmpu_stream_if and bmpu_assembler.
//
// Usage: the req_bytes channel carries the stored BMP pixel array, one byte per
// transaction. The rsp_pixels channel gives one transaction per completed pixel
// with its destination index (row times width plus column, rows flipped when
// bottom_up is set), the RGBA components and a flag on the final pixel.
// Row padding and every byte after the final pixel produce no transaction.
// The csr port writes image_width, image_height, has_alpha and bottom_up; any
// write to these four restarts the image and must be made while the block is idle.
// Throughput: one byte per cycle, sustained while the receiver does not stall.
// The pixel completed by a byte is registered in the pixel record stage and
// then in the result register, which drives rsp_pixels; the index product is
// formed in the second stage. When the receiver stalls, the result register
// and the pixel record stage fill and req_bytes.ready drops until the result
// is taken. Synchronous reset clears both stages, restores the register
// defaults (width 1, height 1, 24-bit pixels, bottom-up) and starts a new image.
`default_nettype none

module bmp_pixel_unpack_rgba (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [bmpu_pkg::CsrIndexBits-1:0]   csr_index,
   input  wire logic [bmpu_pkg::DimWidth-1:0]       csr_write_data,
   bmpu_byte_if.sink                                req_bytes,
   bmpu_pixel_if.source                             rsp_pixels
);

   bmpu_pkg::image_cfg_type cfg_ff, cfg_in;
   logic                    restart;

   logic                    byte_take;
   logic                    pixel_done;
   bmpu_pkg::pixel_rec_type pixel;

   logic                    rec_valid_ff, rec_valid_in;
   bmpu_pkg::pixel_rec_type rec_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [bmpu_pkg::IndexWidth-1:0] index_ff;
   logic [bmpu_pkg::IndexWidth-1:0] index_in;
   bmpu_pkg::pixel_rec_type rsp_rec_ff;
   logic                    rsp_advance;
   logic                    rec_advance;

   always_comb begin
      cfg_in  = cfg_ff;
      restart = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            bmpu_pkg::CSR_IMAGE_WIDTH: begin
               cfg_in.width = bmpu_pkg::clamp_dim(csr_write_data, bmpu_pkg::MaxWidth);
               restart      = 1'b1;
            end
            bmpu_pkg::CSR_IMAGE_HEIGHT: begin
               cfg_in.height = bmpu_pkg::clamp_dim(csr_write_data, bmpu_pkg::MaxHeight);
               restart       = 1'b1;
            end
            bmpu_pkg::CSR_HAS_ALPHA: begin
               cfg_in.has_alpha = csr_write_data[0];
               restart          = 1'b1;
            end
            bmpu_pkg::CSR_BOTTOM_UP: begin
               cfg_in.bottom_up = csr_write_data[0];
               restart          = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width     <= bmpu_pkg::DimWidth'(1);
         cfg_ff.height    <= bmpu_pkg::DimWidth'(1);
         cfg_ff.has_alpha <= 1'b0;
         cfg_ff.bottom_up <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign rsp_advance     = !rsp_valid_ff || rsp_pixels.ready;
   assign rec_advance     = !rec_valid_ff || rsp_advance;
   assign req_bytes.ready = rec_advance;
   assign byte_take       = req_bytes.valid && rec_advance;

   bmpu_assembler u_assembler (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .cfg        (cfg_ff),
      .byte_take  (byte_take),
      .data_byte  (req_bytes.data_byte),
      .pixel_done (pixel_done),
      .pixel      (pixel)
   );

   always_comb begin
      rec_valid_in = rec_valid_ff;
      if (rec_advance) begin
         rec_valid_in = pixel_done;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_advance) begin
         rsp_valid_in = rec_valid_ff;
      end
      index_in = bmpu_pkg::IndexWidth'(rec_ff.dest_row * cfg_ff.width)
                 + bmpu_pkg::IndexWidth'(rec_ff.column);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rec_valid_ff <= rec_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_advance && pixel_done) begin
         rec_ff <= pixel;
      end
      if (rsp_advance && rec_valid_ff) begin
         index_ff   <= index_in;
         rsp_rec_ff <= rec_ff;
      end
   end

   assign rsp_pixels.valid       = rsp_valid_ff;
   assign rsp_pixels.pixel_index = index_ff;
   assign rsp_pixels.red         = rsp_rec_ff.red;
   assign rsp_pixels.green       = rsp_rec_ff.green;
   assign rsp_pixels.blue        = rsp_rec_ff.blue;
   assign rsp_pixels.alpha       = rsp_rec_ff.alpha;
   assign rsp_pixels.last        = rsp_rec_ff.last;

endmodule

`default_nettype wire

@@ rtl/bmpu_checker.sv @@
// Port-level checks for the BMP pixel unpacker, attached to the top level by
// the bind statement below. Depends on bmp_pixel_unpack_rgba.
`default_nettype none

module bmpu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [23:0] rsp_pixel_index
);

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_index))
      else $error("Result transaction changed while stalled.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("Result appeared without a byte transaction two cycles earlier.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Input stalled while the result register was empty.");

endmodule

bind bmp_pixel_unpack_rgba bmpu_checker u_bmpu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bytes.valid),
   .req_ready       (req_bytes.ready),
   .rsp_valid       (rsp_pixels.valid),
   .rsp_ready       (rsp_pixels.ready),
   .rsp_pixel_index (rsp_pixels.pixel_index)
);

`default_nettype wire

@@ test/bmp_pixel_unpack_rgba_tb.sv @@
// Self-checking testbench for bmp_pixel_unpack_rgba: a directed table followed by random
// BMP images, every pixel transaction compared against a table entry or an in-bench predictor.
// Depends on bmpu_pkg, bmpu_stream_if and the unpacker RTL.
module bmp_pixel_unpack_rgba_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned DrainCycles = 6;
   localparam int unsigned MaxReports  = 10;
   localparam int unsigned RandomBytes = 600;
   localparam int unsigned IdlePercent = 23;

   localparam logic [bmpu_pkg::CsrIndexBits-1:0] CsrUnusedFirst = 3'd4;
   localparam logic [bmpu_pkg::CsrIndexBits-1:0] CsrUnusedLast  = 3'd7;
   localparam logic [bmpu_pkg::DimWidth-1:0]     DimAllOnes     = 13'h1FFF;
   localparam logic [7:0]                        Opaque         = bmpu_pkg::OpaqueAlpha;

   typedef struct packed {
      logic [bmpu_pkg::IndexWidth-1:0] pixel_index;
      logic [7:0]                      red;
      logic [7:0]                      green;
      logic [7:0]                      blue;
      logic [7:0]                      alpha;
      logic                            last;
   } rgba_pixel_type;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                         kind;
      logic [bmpu_pkg::CsrIndexBits-1:0]    csr_addr;
      logic [bmpu_pkg::DimWidth-1:0]        value;
      logic                                 typed;
      rgba_pixel_type                       pixel;
   } stimulus_row_type;

   localparam rgba_pixel_type NoPixel = '0;
   localparam int unsigned DirectedCount = 38;

   localparam stimulus_row_type DirectedRows [DirectedCount] = '{
      '{ROW_BYTE, '0, 13'h000, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h0FF, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h05A, 1'b1, '{24'h000000, 8'h5A, 8'hFF, 8'h00, Opaque, 1'b1}},
      '{ROW_BYTE, '0, 13'h0A5, 1'b0, NoPixel},
      '{ROW_CSR, CsrUnusedLast, DimAllOnes, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h011, 1'b0, NoPixel},
      '{ROW_CSR, bmpu_pkg::CSR_HAS_ALPHA, DimAllOnes, 1'b0, NoPixel},
      '{ROW_CSR, bmpu_pkg::CSR_BOTTOM_UP, 13'h1FFE, 1'b0, NoPixel},
      '{ROW_CSR, bmpu_pkg::CSR_IMAGE_HEIGHT, 13'h000, 1'b0, NoPixel},
      '{ROW_CSR, bmpu_pkg::CSR_IMAGE_WIDTH, 13'h002, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h000, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h000, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h000, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h000, 1'b1, '{24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
      '{ROW_BYTE, '0, 13'h0FF, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h0FF, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h0FF, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h0FF, 1'b1, '{24'h000001, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1}},
      '{ROW_CSR, bmpu_pkg::CSR_HAS_ALPHA, 13'h000, 1'b0, NoPixel},
      '{ROW_CSR, bmpu_pkg::CSR_BOTTOM_UP, 13'h001, 1'b0, NoPixel},
      '{ROW_CSR, bmpu_pkg::CSR_IMAGE_WIDTH, 13'h001, 1'b0, NoPixel},
      '{ROW_CSR, bmpu_pkg::CSR_IMAGE_HEIGHT, 13'h002, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h012, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h034, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h056, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h0C3, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h09A, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h0BC, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h0DE, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h077, 1'b0, NoPixel},
      '{ROW_CSR, bmpu_pkg::CSR_IMAGE_WIDTH, DimAllOnes, 1'b0, NoPixel},
      '{ROW_CSR, bmpu_pkg::CSR_IMAGE_HEIGHT, DimAllOnes, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h001, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h002, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h003, 1'b1, '{24'hFFF000, 8'h03, 8'h02, 8'h01, Opaque, 1'b0}},
      '{ROW_BYTE, '0, 13'h080, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h040, 1'b0, NoPixel},
      '{ROW_BYTE, '0, 13'h020, 1'b0, NoPixel}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [bmpu_pkg::CsrIndexBits-1:0] csr_index;
   logic [bmpu_pkg::DimWidth-1:0] csr_write_data;

   bmpu_byte_if  byte_ch ();
   bmpu_pixel_if pixel_ch ();

   bmp_pixel_unpack_rgba u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_bytes      (byte_ch),
      .rsp_pixels     (pixel_ch)
   );

   // Predictor state: image settings and the position within the stored pixel array.
   logic [bmpu_pkg::DimWidth-1:0] cfg_width     = 13'd1;
   logic [bmpu_pkg::DimWidth-1:0] cfg_height    = 13'd1;
   logic                          cfg_has_alpha = 1'b0;
   logic                          cfg_bottom_up = 1'b1;
   logic [1:0]                    px_phase      = '0;
   logic [23:0]                   px_held       = '0;
   logic [bmpu_pkg::DimWidth-1:0] px_column     = '0;
   logic [bmpu_pkg::DimWidth-1:0] px_row        = '0;
   logic [1:0]                    pad_skip      = '0;
   logic                          img_done      = 1'b0;

   rgba_pixel_type expected_pixels [$];
   rgba_pixel_type seen_pixel;
   rgba_pixel_type wanted_pixel;

   bit          no_idle = 1'b0;
   int unsigned cycle_count    = 0;
   int unsigned mismatches     = 0;
   int unsigned pixels_checked = 0;
   int unsigned bytes_consumed = 0;
   int unsigned setups         = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [bmpu_pkg::DimWidth-1:0] limit_dimension(
         input logic [bmpu_pkg::DimWidth-1:0] value,
         input logic [bmpu_pkg::DimWidth-1:0] limit);
      if (value == '0) return bmpu_pkg::DimWidth'(1);
      if (value > limit) return limit;
      return value;
   endfunction

   function automatic void apply_csr_write(input logic [bmpu_pkg::CsrIndexBits-1:0] addr,
                                           input logic [bmpu_pkg::DimWidth-1:0] data);
      case (addr)
         bmpu_pkg::CSR_IMAGE_WIDTH:  cfg_width = limit_dimension(data, bmpu_pkg::MaxWidth);
         bmpu_pkg::CSR_IMAGE_HEIGHT: cfg_height = limit_dimension(data, bmpu_pkg::MaxHeight);
         bmpu_pkg::CSR_HAS_ALPHA:    cfg_has_alpha = data[0];
         bmpu_pkg::CSR_BOTTOM_UP:    cfg_bottom_up = data[0];
         default:                    return;
      endcase
      px_phase  = '0;
      px_held   = '0;
      px_column = '0;
      px_row    = '0;
      pad_skip  = '0;
      img_done  = 1'b0;
   endfunction

   function automatic bit predict_pixel(input logic [7:0] value, output rgba_pixel_type pixel);
      logic [1:0]                    final_phase;
      logic [bmpu_pkg::DimWidth-1:0] dest_row;
      logic [25:0]                   full_index;
      pixel = '0;
      if (img_done) return 1'b0;
      if (pad_skip != '0) begin
         pad_skip = pad_skip - 2'd1;
         return 1'b0;
      end
      final_phase = cfg_has_alpha ? 2'd3 : 2'd2;
      if (px_phase < final_phase) begin
         px_held[8*px_phase +: 8] = value;
         px_phase = px_phase + 2'd1;
         return 1'b0;
      end
      if (cfg_has_alpha) begin
         pixel.alpha = value;
      end else begin
         px_held[23:16] = value;
         pixel.alpha = Opaque;
      end
      dest_row = cfg_bottom_up ? (cfg_height - 13'd1 - px_row) : px_row;
      full_index = 26'(dest_row) * 26'(cfg_width) + 26'(px_column);
      pixel.pixel_index = full_index[bmpu_pkg::IndexWidth-1:0];
      pixel.red   = px_held[23:16];
      pixel.green = px_held[15:8];
      pixel.blue  = px_held[7:0];
      pixel.last  = (px_row == cfg_height - 13'd1) && (px_column == cfg_width - 13'd1);
      px_phase  = '0;
      px_held   = '0;
      px_column = px_column + 13'd1;
      if (px_column >= cfg_width) begin
         px_column = '0;
         px_row = px_row + 13'd1;
         pad_skip = cfg_has_alpha ? 2'd0 : cfg_width[1:0];
         if (px_row >= cfg_height) img_done = 1'b1;
      end
      return 1'b1;
   endfunction

   // Called at a falling edge; returns at a falling edge after the transaction.
   task automatic send_byte(input logic [7:0] value, input logic typed,
                            input rgba_pixel_type typed_pixel);
      rgba_pixel_type pixel;
      while (!no_idle && $urandom_range(99) < IdlePercent) begin
         byte_ch.valid <= 1'b0;
         @(negedge clock);
      end
      byte_ch.valid     <= 1'b1;
      byte_ch.data_byte <= value;
      @(posedge clock);
      while (!byte_ch.ready) @(posedge clock);
      if (!img_done) bytes_consumed++;
      if (predict_pixel(value, pixel)) expected_pixels.push_back(typed ? typed_pixel : pixel);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      byte_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_csr(input logic [bmpu_pkg::CsrIndexBits-1:0] addr,
                            input logic [bmpu_pkg::DimWidth-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= addr;
      csr_write_data <= data;
      @(posedge clock);
      apply_csr_write(addr, data);
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random_image();
      int unsigned                   pick;
      int unsigned                   width_raw;
      int unsigned                   height_raw;
      int unsigned                   row_bytes;
      int unsigned                   total;
      int unsigned                   trailing;
      int unsigned                   pause_at;
      logic [bmpu_pkg::DimWidth-1:0] flag_word;
      setups++;
      no_idle = (setups >= 5 && setups <= 7);
      pick = $urandom_range(99);
      if (pick < 5) begin
         width_raw  = $urandom_range(1) ? 32'(bmpu_pkg::MaxWidth) : 32'(DimAllOnes);
         height_raw = $urandom_range(1) ? 32'(bmpu_pkg::MaxHeight) : 32'(DimAllOnes);
      end else if (pick < 15) begin
         width_raw  = $urandom_range(12, 40);
         height_raw = $urandom_range(1, 2);
      end else begin
         width_raw  = $urandom_range(0, 11);
         height_raw = $urandom_range(0, 4);
      end
      wait_idle();
      flag_word = bmpu_pkg::DimWidth'($urandom);
      flag_word[0] = 1'($urandom_range(1));
      write_csr(bmpu_pkg::CSR_HAS_ALPHA, flag_word);
      flag_word = bmpu_pkg::DimWidth'($urandom);
      flag_word[0] = 1'($urandom_range(1));
      write_csr(bmpu_pkg::CSR_BOTTOM_UP, flag_word);
      write_csr(bmpu_pkg::CSR_IMAGE_WIDTH, bmpu_pkg::DimWidth'(width_raw));
      write_csr(bmpu_pkg::CSR_IMAGE_HEIGHT, bmpu_pkg::DimWidth'(height_raw));
      row_bytes = cfg_width * (cfg_has_alpha ? 4 : 3) + (cfg_has_alpha ? 0 : cfg_width % 4);
      total = row_bytes * cfg_height;
      trailing = 0;
      if (pick < 5) begin
         total = $urandom_range(3, 30);
      end else if ($urandom_range(4) == 0) begin
         total = $urandom_range(1, total);
      end else begin
         trailing = $urandom_range(0, 4);
      end
      pause_at = (setups == 2 || $urandom_range(7) == 0) ? $urandom_range(0, total - 1) : total;
      for (int unsigned n = 0; n < total + trailing; n++) begin
         if (n == pause_at) begin
            wait_idle();
            if ($urandom_range(1))
               write_csr(bmpu_pkg::CsrIndexBits'($urandom_range(CsrUnusedFirst, CsrUnusedLast)),
                         bmpu_pkg::DimWidth'($urandom));
         end
         send_byte(8'($urandom_range(255)), 1'b0, NoPixel);
      end
   endtask

   initial begin
      int unsigned random_start;
      reset             = 1'b1;
      csr_write_en      = 1'b0;
      csr_index         = '0;
      csr_write_data    = '0;
      byte_ch.valid     = 1'b0;
      byte_ch.data_byte = '0;
      pixel_ch.ready    = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int unsigned i = 0; i < DirectedCount; i++) begin
         if (DirectedRows[i].kind == ROW_CSR) begin
            wait_idle();
            write_csr(DirectedRows[i].csr_addr, DirectedRows[i].value);
         end else begin
            send_byte(DirectedRows[i].value[7:0], DirectedRows[i].typed, DirectedRows[i].pixel);
         end
      end

      random_start = bytes_consumed;
      while (bytes_consumed - random_start < RandomBytes) run_random_image();
      no_idle = 1'b0;
      wait_idle();

      $display("Run covered %0d image setups and %0d pixel bytes; %0d pixel transactions checked.",
               setups + 4, bytes_consumed, pixels_checked);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   always @(negedge clock) begin
      pixel_ch.ready <= no_idle || ($urandom_range(99) >= IdlePercent);
   end

   always @(posedge clock) begin
      if (!reset && pixel_ch.valid && pixel_ch.ready) begin
         seen_pixel = '{pixel_ch.pixel_index, pixel_ch.red, pixel_ch.green, pixel_ch.blue,
                        pixel_ch.alpha, pixel_ch.last};
         pixels_checked++;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("Unexpected pixel transaction: index %0d rgba %02h %02h %02h %02h last %0b",
                        seen_pixel.pixel_index, seen_pixel.red, seen_pixel.green,
                        seen_pixel.blue, seen_pixel.alpha, seen_pixel.last);
         end else begin
            wanted_pixel = expected_pixels.pop_front();
            if (seen_pixel !== wanted_pixel) begin
               mismatches++;
               if (mismatches <= MaxReports) begin
                  $display("Pixel mismatch: expected index %0d rgba %02h %02h %02h %02h last %0b",
                           wanted_pixel.pixel_index, wanted_pixel.red, wanted_pixel.green,
                           wanted_pixel.blue, wanted_pixel.alpha, wanted_pixel.last);
                  $display("                got index %0d rgba %02h %02h %02h %02h last %0b",
                           seen_pixel.pixel_index, seen_pixel.red, seen_pixel.green,
                           seen_pixel.blue, seen_pixel.alpha, seen_pixel.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Timed out after %0d cycles with %0d pixels outstanding.",
                  cycle_count, expected_pixels.size());
         $display("simulation failed");
         $finish;
      end
   end

endmodule

@@ files.f @@
rtl/bmpu_pkg.sv
rtl/bmpu_stream_if.sv
rtl/bmpu_assembler.sv
rtl/bmp_pixel_unpack_rgba.sv
rtl/bmpu_checker.sv
test/bmp_pixel_unpack_rgba_tb.sv
